// ----- rtl/rcca_pkg.sv -----
// ----------------------------------------------------------------------------
// rcca_pkg
// Shared widths, register indexes, types and helpers of the rounded corner
// coverage alpha unit.
// ----------------------------------------------------------------------------
package rcca_pkg;

	// field widths
	localparam int OFS_W   = 11;
	localparam int BOX_W   = 12;
	localparam int RAD_W   = 11;
	localparam int E8_W    = RAD_W + 3;
	localparam int SQ_W    = 2 * E8_W;
	localparam int ALPHA_W = 8;
	localparam int RGB_W   = 24;
	localparam int COLOR_W = 32;
	localparam int CNT_W   = 5;
	localparam int NSUB    = 4;
	localparam int NSAMP   = NSUB * NSUB;

	// configuration port
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_BOX_WIDTH     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BOX_HEIGHT    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CORNER_RADIUS = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RING_WIDTH    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_RING_MODE     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_DRAW_COLOR    = 3'd5;

	// register reset values
	localparam logic [BOX_W-1:0]   BOX_RST   = 12'd64;
	localparam logic [RAD_W-1:0]   RADIUS_RST = 11'd0;
	localparam logic [RAD_W-1:0]   RING_RST  = 11'd1;
	localparam logic [COLOR_W-1:0] COLOR_RST = 32'hFF00_0000;

	// half-pixel pull-in of a one pixel ring, in eighths
	localparam logic [E8_W-1:0] HALF_PIX_E8 = 14'd4;
	localparam logic [ALPHA_W-1:0] ALPHA_FULL = 8'hFF;

	// derived corner setup shared with the datapath
	typedef struct packed {
		logic               en;
		logic               ring;
		logic [RAD_W-1:0]   r_eff;
		logic [SQ_W-1:0]    lim_out;
		logic [SQ_W-1:0]    lim_in;
		logic [ALPHA_W-1:0] fg;
		logic [RGB_W-1:0]   rgb;
	} cfg_t;

	typedef logic [NSUB-1:0][SQ_W-1:0] sq_vec_t;

	// subsample position in eighths inside a pixel: 1,3,5,7
	function automatic logic [E8_W-1:0] sub_pos(input int k);
		return E8_W'(2 * k + 1);
	endfunction

	// number of set bits of a 16 bit hit mask
	function automatic logic [CNT_W-1:0] popcnt16(input logic [NSAMP-1:0] v);
		logic [3:0][2:0] nib;
		for (int n = 0; n < 4; n++) begin
			nib[n] = 3'(v[4*n]) + 3'(v[4*n+1]) + 3'(v[4*n+2]) + 3'(v[4*n+3]);
		end
		return (CNT_W'(nib[0]) + CNT_W'(nib[1])) + (CNT_W'(nib[2]) + CNT_W'(nib[3]));
	endfunction

endpackage

// ----- rtl/rcca_if.sv -----
// ----------------------------------------------------------------------------
// rcca_if
// Valid/ready channels of the rounded corner coverage alpha unit: pixel
// offsets in, pixel results out, and the configuration write channel.
// ----------------------------------------------------------------------------
interface rcca_in_if;
	import rcca_pkg::*;
	logic             valid;
	logic             ready;
	logic [OFS_W-1:0] offset_x;
	logic [OFS_W-1:0] offset_y;

	modport source (output valid, output offset_x, output offset_y, input ready);
	modport sink   (input valid, input offset_x, input offset_y, output ready);
endinterface

interface rcca_out_if;
	import rcca_pkg::*;
	logic               valid;
	logic               ready;
	logic               write_pixel;
	logic [ALPHA_W-1:0] alpha;
	logic               opaque;
	logic [RGB_W-1:0]   pixel_rgb;

	modport source (output valid, output write_pixel, output alpha, output opaque,
		output pixel_rgb, input ready);
	modport sink   (input valid, input write_pixel, input alpha, input opaque,
		input pixel_rgb, output ready);
endinterface

interface rcca_cfg_if;
	import rcca_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_DAT_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/rcca_cfg.sv -----
// ----------------------------------------------------------------------------
// rcca_cfg
// Configuration registers and the derived corner setup: effective radius,
// clamped ring width and squared outer/inner limits in eighths.
// ----------------------------------------------------------------------------
module rcca_cfg #(
	parameter int MAX_RADIUS = 2048
) (
	input  logic             clk,
	input  logic             arst_n,
	rcca_cfg_if.sink         cfg,
	output rcca_pkg::cfg_t   cfg_d
);
	import rcca_pkg::*;

	logic [BOX_W-1:0]   box_w_q;
	logic [BOX_W-1:0]   box_h_q;
	logic [RAD_W-1:0]   radius_q;
	logic [RAD_W-1:0]   ring_w_q;
	logic               ring_mode_q;
	logic [COLOR_W-1:0] color_q;

	logic [RAD_W-1:0]   r_c;
	logic [RAD_W-1:0]   rw_c;
	logic [RAD_W-1:0]   diff_c;
	logic [E8_W-1:0]    inner_c;

	logic               en_q;
	logic [RAD_W-1:0]   r_q;
	logic [E8_W-1:0]    inner8_q;
	logic [E8_W-1:0]    rad8;
	logic [SQ_W-1:0]    lim_out_q;
	logic [SQ_W-1:0]    lim_in_q;

	assign cfg.ready = 1'b1;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_w_q     <= BOX_RST;
			box_h_q     <= BOX_RST;
			radius_q    <= RADIUS_RST;
			ring_w_q    <= RING_RST;
			ring_mode_q <= 1'b0;
			color_q     <= COLOR_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_BOX_WIDTH:     box_w_q     <= cfg.data[BOX_W-1:0];
				REG_BOX_HEIGHT:    box_h_q     <= cfg.data[BOX_W-1:0];
				REG_CORNER_RADIUS: radius_q    <= cfg.data[RAD_W-1:0];
				REG_RING_WIDTH:    ring_w_q    <= cfg.data[RAD_W-1:0];
				REG_RING_MODE:     ring_mode_q <= cfg.data[0];
				REG_DRAW_COLOR:    color_q     <= cfg.data[COLOR_W-1:0];
				default: ;
			endcase
		end
	end

	// effective radius, ring width and inner radius
	always_comb begin
		r_c = radius_q;
		if (box_w_q[BOX_W-1:1] < r_c) r_c = box_w_q[BOX_W-1:1];
		if (box_h_q[BOX_W-1:1] < r_c) r_c = box_h_q[BOX_W-1:1];
		if ((RAD_W + 2)'(r_c) > (RAD_W + 2)'(MAX_RADIUS)) r_c = RAD_W'(MAX_RADIUS);
		rw_c = ring_w_q;
		if (rw_c > {1'b0, r_c[RAD_W-1:1]}) rw_c = {1'b0, r_c[RAD_W-1:1]};
		diff_c  = r_c - rw_c;
		inner_c = {diff_c, 3'b000};
		// a one pixel ring pulls the inner edge in by half a pixel
		if (rw_c == RAD_W'(1)) inner_c = inner_c - HALF_PIX_E8;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q     <= 1'b0;
			r_q      <= '0;
			inner8_q <= '0;
		end else begin
			en_q     <= (radius_q > RAD_W'(1));
			r_q      <= r_c;
			inner8_q <= inner_c;
		end
	end

	// squared limits
	assign rad8 = {r_q, 3'b000};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_out_q <= '0;
			lim_in_q  <= '0;
		end else begin
			lim_out_q <= {{E8_W{1'b0}}, rad8} * {{E8_W{1'b0}}, rad8};
			lim_in_q  <= {{E8_W{1'b0}}, inner8_q} * {{E8_W{1'b0}}, inner8_q};
		end
	end

	always_comb begin
		cfg_d.en      = en_q;
		cfg_d.ring    = ring_mode_q;
		cfg_d.r_eff   = r_q;
		cfg_d.lim_out = lim_out_q;
		cfg_d.lim_in  = lim_in_q;
		cfg_d.fg      = color_q[COLOR_W-1:RGB_W];
		cfg_d.rgb     = color_q[RGB_W-1:0];
	end

endmodule

// ----- rtl/rcca_sqr.sv -----
// ----------------------------------------------------------------------------
// rcca_sqr
// Squares of the four subsample positions on each axis, in eighths, and the
// corner square test.
// ----------------------------------------------------------------------------
module rcca_sqr (
	input  logic                        clk,
	input  logic                        load,
	input  logic [rcca_pkg::OFS_W-1:0]  dx,
	input  logic [rcca_pkg::OFS_W-1:0]  dy,
	input  rcca_pkg::cfg_t              cfg_d,
	output rcca_pkg::sq_vec_t           sqx_s2,
	output rcca_pkg::sq_vec_t           sqy_s2,
	output logic                        live_s2
);
	import rcca_pkg::*;

	logic [NSUB-1:0][E8_W-1:0] sx;
	logic [NSUB-1:0][E8_W-1:0] sy;
	sq_vec_t                   sqx;
	sq_vec_t                   sqy;

	// subsample coordinates and their squares
	always_comb begin
		for (int k = 0; k < NSUB; k++) begin
			sx[k]  = {dx, 3'b000} + sub_pos(k);
			sy[k]  = {dy, 3'b000} + sub_pos(k);
			sqx[k] = {{E8_W{1'b0}}, sx[k]} * {{E8_W{1'b0}}, sx[k]};
			sqy[k] = {{E8_W{1'b0}}, sy[k]} * {{E8_W{1'b0}}, sy[k]};
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			sqx_s2  <= sqx;
			sqy_s2  <= sqy;
			live_s2 <= cfg_d.en && (dx < cfg_d.r_eff) && (dy < cfg_d.r_eff);
		end
	end

endmodule

// ----- rtl/rcca_cmp.sv -----
// ----------------------------------------------------------------------------
// rcca_cmp
// Distance test of all 16 subsamples against the outer and inner disks.
// ----------------------------------------------------------------------------
module rcca_cmp (
	input  logic                          clk,
	input  logic                          load,
	input  rcca_pkg::sq_vec_t             sqx_s2,
	input  rcca_pkg::sq_vec_t             sqy_s2,
	input  logic                          live_s2,
	input  rcca_pkg::cfg_t                cfg_d,
	output logic [rcca_pkg::NSAMP-1:0]    hit_out_s3,
	output logic [rcca_pkg::NSAMP-1:0]    hit_in_s3,
	output logic                          live_s3
);
	import rcca_pkg::*;

	logic [NSAMP-1:0][SQ_W:0] dsq;
	logic [NSAMP-1:0]         hit_out;
	logic [NSAMP-1:0]         hit_in;

	// squared distance per subsample, row i on y and column j on x
	always_comb begin
		for (int i = 0; i < NSUB; i++) begin
			for (int j = 0; j < NSUB; j++) begin
				dsq[i*NSUB+j]     = {1'b0, sqx_s2[j]} + {1'b0, sqy_s2[i]};
				hit_out[i*NSUB+j] = dsq[i*NSUB+j] <= {1'b0, cfg_d.lim_out};
				hit_in[i*NSUB+j]  = dsq[i*NSUB+j] <= {1'b0, cfg_d.lim_in};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			hit_out_s3 <= hit_out;
			hit_in_s3  <= hit_in;
			live_s3    <= live_s2;
		end
	end

endmodule

// ----- rtl/rcca_shade.sv -----
// ----------------------------------------------------------------------------
// rcca_shade
// Coverage count with ring subtraction, then alpha scaling and the result
// register.
// ----------------------------------------------------------------------------
module rcca_shade (
	input  logic                           clk,
	input  logic                           load4,
	input  logic                           load5,
	input  logic [rcca_pkg::NSAMP-1:0]     hit_out_s3,
	input  logic [rcca_pkg::NSAMP-1:0]     hit_in_s3,
	input  logic                           live_s3,
	input  rcca_pkg::cfg_t                 cfg_d,
	output logic                           write_pixel_s5,
	output logic [rcca_pkg::ALPHA_W-1:0]   alpha_s5,
	output logic                           opaque_s5,
	output logic [rcca_pkg::RGB_W-1:0]     rgb_s5
);
	import rcca_pkg::*;

	logic [CNT_W-1:0]         cnt_out;
	logic [CNT_W-1:0]         cnt_in;
	logic [CNT_W-1:0]         cov;
	logic [CNT_W-1:0]         cov_s4;
	logic [ALPHA_W+CNT_W-1:0] prod;
	logic [ALPHA_W-1:0]       alpha;

	// coverage count, ring keeps only samples outside the inner disk
	always_comb begin
		cnt_out = popcnt16(hit_out_s3);
		cnt_in  = popcnt16(hit_in_s3);
		cov     = cnt_out;
		if (cfg_d.ring) cov = (cnt_out > cnt_in) ? cnt_out - cnt_in : '0;
		if (!live_s3) cov = '0;
	end

	always_ff @(posedge clk) begin
		if (load4) cov_s4 <= cov;
	end

	// alpha = floor(fg * cov / 16)
	assign prod  = {{CNT_W{1'b0}}, cfg_d.fg} * {{ALPHA_W{1'b0}}, cov_s4};
	assign alpha = prod[ALPHA_W+3:4];

	always_ff @(posedge clk) begin
		if (load5) begin
			alpha_s5       <= alpha;
			write_pixel_s5 <= (alpha != '0);
			opaque_s5      <= (alpha == ALPHA_FULL);
			rgb_s5         <= cfg_d.rgb;
		end
	end

endmodule

// ----- rtl/rounded_corner_coverage_alpha_core.sv -----
// ----------------------------------------------------------------------------
// rounded_corner_coverage_alpha_core
// Pipeline: five register stages carry an accepted offset to its result on
// pix_out, the input register being the first.
// Throughput: one pixel per cycle while pix_out is ready; a stage holds under
// back-pressure and bubbles fill in behind a waiting result.
// Reset: arst_n clears pipeline valids and loads the register defaults.
// ----------------------------------------------------------------------------
module rounded_corner_coverage_alpha_core #(
	parameter int MAX_RADIUS = 2048
) (
	input  logic        clk,
	input  logic        arst_n,
	rcca_in_if.sink     pix_in,
	rcca_out_if.source  pix_out,
	rcca_cfg_if.sink    cfg
);
	import rcca_pkg::*;

	cfg_t              cfg_d;

	logic              vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic              rdy1, rdy2, rdy3, rdy4, rdy5;
	logic [OFS_W-1:0]  dx_s1;
	logic [OFS_W-1:0]  dy_s1;
	sq_vec_t           sqx_s2;
	sq_vec_t           sqy_s2;
	logic              live_s2;
	logic [NSAMP-1:0]  hit_out_s3;
	logic [NSAMP-1:0]  hit_in_s3;
	logic              live_s3;

	// configuration and derived corner setup
	rcca_cfg #(
		.MAX_RADIUS(MAX_RADIUS)
	) u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.cfg_d  (cfg_d)
	);

	// stage ready chain: a stage loads when empty or when the next one moves
	assign rdy5 = !vld_s5 || pix_out.ready;
	assign rdy4 = !vld_s4 || rdy5;
	assign rdy3 = !vld_s3 || rdy4;
	assign rdy2 = !vld_s2 || rdy3;
	assign rdy1 = !vld_s1 || rdy2;
	assign pix_in.ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			if (rdy1) vld_s1 <= pix_in.valid;
			if (rdy2) vld_s2 <= vld_s1;
			if (rdy3) vld_s3 <= vld_s2;
			if (rdy4) vld_s4 <= vld_s3;
			if (rdy5) vld_s5 <= vld_s4;
		end
	end

	// input register
	always_ff @(posedge clk) begin
		if (rdy1 && pix_in.valid) begin
			dx_s1 <= pix_in.offset_x;
			dy_s1 <= pix_in.offset_y;
		end
	end

	rcca_sqr u_sqr (
		.clk     (clk),
		.load    (rdy2 && vld_s1),
		.dx      (dx_s1),
		.dy      (dy_s1),
		.cfg_d   (cfg_d),
		.sqx_s2  (sqx_s2),
		.sqy_s2  (sqy_s2),
		.live_s2 (live_s2)
	);

	rcca_cmp u_cmp (
		.clk        (clk),
		.load       (rdy3 && vld_s2),
		.sqx_s2     (sqx_s2),
		.sqy_s2     (sqy_s2),
		.live_s2    (live_s2),
		.cfg_d      (cfg_d),
		.hit_out_s3 (hit_out_s3),
		.hit_in_s3  (hit_in_s3),
		.live_s3    (live_s3)
	);

	rcca_shade u_shade (
		.clk            (clk),
		.load4          (rdy4 && vld_s3),
		.load5          (rdy5 && vld_s4),
		.hit_out_s3     (hit_out_s3),
		.hit_in_s3      (hit_in_s3),
		.live_s3        (live_s3),
		.cfg_d          (cfg_d),
		.write_pixel_s5 (pix_out.write_pixel),
		.alpha_s5       (pix_out.alpha),
		.opaque_s5      (pix_out.opaque),
		.rgb_s5         (pix_out.pixel_rgb)
	);

	assign pix_out.valid = vld_s5;

`ifndef SYNTHESIS
	// inner disk never exceeds the outer disk
	a_lim_order: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_d.lim_in <= cfg_d.lim_out)
		else $error("inner limit above outer limit");

	// result flags agree with alpha
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		pix_out.valid |-> ((pix_out.write_pixel == (pix_out.alpha != '0)) &&
			(pix_out.opaque == (pix_out.alpha == ALPHA_FULL))))
		else $error("result flags inconsistent with alpha");

	// a result waiting at the output does not close the input side while stage one is empty
	a_no_block: assert property (@(posedge clk) disable iff (!arst_n)
		!vld_s1 |-> pix_in.ready)
		else $error("input stalled with empty first stage");
`endif

endmodule

// ----- verif/rcca_alpha_checker.sv -----
// ----------------------------------------------------------------------------
// rcca_alpha_checker
// Watches the configuration, offset and result channels of the rounded
// corner coverage alpha unit. It keeps a shadow copy of the registers and
// predicts each pixel result by counting the 16 subsamples in eighths. It
// checks the results in order and hands the failure count to the top.
// ----------------------------------------------------------------------------
module rcca_alpha_checker #(
	parameter int MAX_RADIUS = 2048
) (
	input  logic clk,
	input  logic arst_n,
	rcca_in_if   pix_in,
	rcca_out_if  pix_out,
	rcca_cfg_if  cfg,
	output int   fail_count,
	output int   outstanding
);
	import rcca_pkg::*;

	localparam int REPORT_CAP = 60;

	typedef struct {
		logic               write_pixel;
		logic [ALPHA_W-1:0] alpha;
		logic               opaque;
		logic [RGB_W-1:0]   pixel_rgb;
	} pixel_result_t;

	// shadow copy of the register file
	logic [BOX_W-1:0]   box_w;
	logic [BOX_W-1:0]   box_h;
	logic [RAD_W-1:0]   radius;
	logic [RAD_W-1:0]   ring_w;
	logic               ring_on;
	logic [COLOR_W-1:0] color;

	pixel_result_t expected_pixels[$];

	initial begin
		fail_count = 0;
		outstanding = 0;
	end

	// subsamples of pixel (px,py) inside a disk of radius rad8, all in eighths
	function automatic int unsigned subsample_hits(input longint px, input longint py,
		input longint rad8);
		longint sx;
		longint sy;
		int unsigned n;
		n = 0;
		for (int i = 0; i < NSUB; i++) begin
			sy = py * 8 + 2 * i + 1;
			for (int j = 0; j < NSUB; j++) begin
				sx = px * 8 + 2 * j + 1;
				if (sx * sx + sy * sy <= rad8 * rad8)
					n++;
			end
		end
		return n;
	endfunction

	// expected result of one pixel offset under the current registers
	function automatic pixel_result_t predict_corner_pixel(input logic [OFS_W-1:0] dx,
		input logic [OFS_W-1:0] dy);
		pixel_result_t res;
		int unsigned r;
		int unsigned rw;
		int unsigned hits;
		int unsigned inner_hits;
		int unsigned level;
		longint inner8;
		level = 0;
		if (radius > 1) begin
			r = radius;
			if (r > box_w / 2) r = box_w / 2;
			if (r > box_h / 2) r = box_h / 2;
			if (r > MAX_RADIUS) r = MAX_RADIUS;
			if (dx < r && dy < r) begin
				hits = subsample_hits(dx, dy, longint'(r) * 8);
				if (ring_on) begin
					// inner disk of the ring, pulled in half a pixel for a one pixel ring
					rw = ring_w;
					if (rw > r / 2) rw = r / 2;
					inner8 = (longint'(r) - longint'(rw)) * 8;
					if (rw == 1) inner8 = inner8 - longint'(HALF_PIX_E8);
					if (inner8 < 0) inner8 = 0;
					inner_hits = (inner8 > 0) ? subsample_hits(dx, dy, inner8) : 0;
					hits = (hits > inner_hits) ? hits - inner_hits : 0;
				end
				level = (int'(color[31:24]) * hits) / NSAMP;
			end
		end
		res.write_pixel = (level > 0);
		res.alpha = level[ALPHA_W-1:0];
		res.opaque = (level == ALPHA_FULL);
		res.pixel_rgb = color[RGB_W-1:0];
		return res;
	endfunction

	task automatic report_mismatch(input string field, input longint want, input longint got);
		fail_count++;
		if (fail_count <= REPORT_CAP)
			$error("%s: expected %0d, actual %0d", field, want, got);
	endtask

	// follow every transaction on the three channels
	always @(posedge clk or negedge arst_n) begin : watch
		pixel_result_t want;
		pixel_result_t got;
		if (!arst_n) begin
			box_w = BOX_RST;
			box_h = BOX_RST;
			radius = RADIUS_RST;
			ring_w = RING_RST;
			ring_on = 1'b0;
			color = COLOR_RST;
			expected_pixels.delete();
			outstanding <= 0;
		end else begin
			// register writes
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					REG_BOX_WIDTH:     box_w = cfg.data[BOX_W-1:0];
					REG_BOX_HEIGHT:    box_h = cfg.data[BOX_W-1:0];
					REG_CORNER_RADIUS: radius = cfg.data[RAD_W-1:0];
					REG_RING_WIDTH:    ring_w = cfg.data[RAD_W-1:0];
					REG_RING_MODE:     ring_on = cfg.data[0];
					REG_DRAW_COLOR:    color = cfg.data[COLOR_W-1:0];
					default: ;
				endcase
			end

			// result against the oldest prediction
			if (pix_out.valid && pix_out.ready) begin
				got.write_pixel = pix_out.write_pixel;
				got.alpha = pix_out.alpha;
				got.opaque = pix_out.opaque;
				got.pixel_rgb = pix_out.pixel_rgb;
				if (expected_pixels.size() == 0) begin
					fail_count++;
					if (fail_count <= REPORT_CAP)
						$error("result transaction with no pixel pending");
				end else begin
					want = expected_pixels.pop_front();
					if (got.write_pixel !== want.write_pixel)
						report_mismatch("write_pixel", want.write_pixel, got.write_pixel);
					if (got.alpha !== want.alpha)
						report_mismatch("alpha", want.alpha, got.alpha);
					if (got.opaque !== want.opaque)
						report_mismatch("opaque", want.opaque, got.opaque);
					if (got.pixel_rgb !== want.pixel_rgb)
						report_mismatch("pixel_rgb", want.pixel_rgb, got.pixel_rgb);
				end
			end

			// new offset
			if (pix_in.valid && pix_in.ready)
				expected_pixels.push_back(predict_corner_pixel(pix_in.offset_x, pix_in.offset_y));

			outstanding <= expected_pixels.size();
		end
	end

endmodule

// ----- verif/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Drives the rounded corner coverage alpha core: directed corner cases
// (disabled corners, outside the corner square, one pixel and zero width
// rings, clamped radius and ring, extreme offsets), then random register
// settings with mostly in-corner offsets. Bursty sender, stalling receiver,
// one long receiver hold-off and one full drain in the middle of a phase.
// ----------------------------------------------------------------------------
module testbench;
	import rcca_pkg::*;

	localparam int MAX_RADIUS    = 2048;
	localparam int RESET_CYCLES  = 8;
	localparam int LONG_HOLD     = 300;
	localparam int STALL_LIMIT   = 2000;
	localparam int TAIL_CYCLES   = 20;
	localparam int RANDOM_PHASES = 12;
	localparam int PHASE_ITEMS   = 125;
	localparam int OFS_MAX       = (1 << OFS_W) - 1;

	localparam bit MODE_FILL = 1'b0;
	localparam bit MODE_RING = 1'b1;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   outstanding;
	int   corner_reach;
	int   hold_requests = 0;

	rcca_in_if  pix_in();
	rcca_out_if pix_out();
	rcca_cfg_if cfg();

	rounded_corner_coverage_alpha_core #(.MAX_RADIUS(MAX_RADIUS)) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.pix_in  (pix_in),
		.pix_out (pix_out),
		.cfg     (cfg)
	);

	rcca_alpha_checker #(.MAX_RADIUS(MAX_RADIUS)) alpha_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.pix_in      (pix_in),
		.pix_out     (pix_out),
		.cfg         (cfg),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// one register write transaction; the caller lowers valid after the last
	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DAT_W-1:0] value);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= value;
		do @(posedge clk); while (!cfg.ready);
	endtask

	// wait until every predicted result has come back
	task automatic wait_idle();
		do @(posedge clk); while (outstanding != 0);
	endtask

	// program all registers once the block is idle
	task automatic apply_setup(input int bw, input int bh, input int r, input int rw,
		input bit ring, input logic [COLOR_W-1:0] color);
		wait_idle();
		write_register(REG_BOX_WIDTH, bw);
		write_register(REG_BOX_HEIGHT, bh);
		write_register(REG_CORNER_RADIUS, r);
		write_register(REG_RING_WIDTH, rw);
		write_register(REG_RING_MODE, CFG_DAT_W'(ring));
		write_register(REG_DRAW_COLOR, color);
		cfg.valid <= 1'b0;
		corner_reach = r;
		if (corner_reach > bw / 2) corner_reach = bw / 2;
		if (corner_reach > bh / 2) corner_reach = bh / 2;
	endtask

	// one offset transaction; valid stays high for the next one
	task automatic push_offset(input int x, input int y);
		pix_in.valid <= 1'b1;
		pix_in.offset_x <= x[OFS_W-1:0];
		pix_in.offset_y <= y[OFS_W-1:0];
		do @(posedge clk); while (!pix_in.ready);
	endtask

	// random offsets in bursts, mostly inside or just past the corner square
	task automatic run_offsets(input int count, input bit hold_off, input bit mid_drain);
		int burst;
		int gap;
		int lim;
		int x;
		int y;
		burst = $urandom_range(1, 16);
		lim = (corner_reach + 1 > OFS_MAX) ? OFS_MAX : corner_reach + 1;
		for (int n = 0; n < count; n++) begin
			if (hold_off && n == 0)
				hold_requests++;
			if (mid_drain && n == count / 2) begin
				pix_in.valid <= 1'b0;
				wait_idle();
			end
			if ($urandom_range(0, 9) < 8) begin
				x = $urandom_range(0, lim);
				y = $urandom_range(0, lim);
			end else begin
				x = $urandom_range(0, OFS_MAX);
				y = $urandom_range(0, OFS_MAX);
			end
			push_offset(x, y);
			burst--;
			if (burst == 0) begin
				burst = $urandom_range(1, 16);
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
				if (gap > 0) begin
					pix_in.valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
		end
		pix_in.valid <= 1'b0;
	endtask

	function automatic int pick_box();
		case ($urandom_range(0, 9))
			0: return $urandom_range(0, 3);
			1: return (1 << BOX_W) - 1;
			2: return $urandom_range(0, (1 << BOX_W) - 1);
			default: return $urandom_range(4, 160);
		endcase
	endfunction

	// receiver: runs of always ready, mostly ready and mostly stalled
	initial begin : receiver
		int run;
		int mode;
		int holds_done;
		holds_done = 0;
		pix_out.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (holds_done != hold_requests) begin
				holds_done = hold_requests;
				pix_out.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end
			mode = $urandom_range(0, 2);
			run = $urandom_range(1, 40);
			repeat (run) begin
				case (mode)
					0: pix_out.ready <= 1'b1;
					1: pix_out.ready <= ($urandom_range(0, 3) != 0);
					default: pix_out.ready <= ($urandom_range(0, 3) == 0);
				endcase
				@(posedge clk);
			end
		end
	end

	// watchdog on cycles without any transaction
	initial begin : watchdog
		int quiet;
		quiet = 0;
		@(posedge arst_n);
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((pix_in.valid && pix_in.ready) || (pix_out.valid && pix_out.ready) ||
				(cfg.valid && cfg.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("testbench: done, errors");
		$finish;
	end

	initial begin : stimulus
		int bw;
		int bh;
		int r;
		int rw;
		logic [COLOR_W-1:0] color;
		arst_n <= 1'b0;
		pix_in.valid <= 1'b0;
		pix_in.offset_x <= '0;
		pix_in.offset_y <= '0;
		cfg.valid <= 1'b0;
		cfg.index <= '0;
		cfg.data <= '0;
		corner_reach = 0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// filled disk: center, far corner, boundary, edges, outside, max offsets
		apply_setup(64, 64, 20, 1, MODE_FILL, 32'hFF12_3456);
		push_offset(0, 0);
		push_offset(19, 19);
		push_offset(14, 14);
		push_offset(19, 0);
		push_offset(20, 0);
		push_offset(0, 20);
		push_offset(OFS_MAX, OFS_MAX);
		push_offset(OFS_MAX, 0);
		pix_in.valid <= 1'b0;

		// writes to unused indexes leave the registers alone
		wait_idle();
		write_register(REG_SPARE_LO, '1);
		write_register(REG_SPARE_HI, 32'h0055_AA00);
		cfg.valid <= 1'b0;
		push_offset(13, 14);
		pix_in.valid <= 1'b0;

		// one pixel ring with the half pixel pull-in, half alpha
		apply_setup(64, 64, 20, 1, MODE_RING, 32'h80AB_CDEF);
		push_offset(19, 0);
		push_offset(0, 19);
		push_offset(13, 13);
		push_offset(0, 0);
		pix_in.valid <= 1'b0;

		// zero ring width covers nothing
		apply_setup(64, 64, 20, 0, MODE_RING, 32'hFFFF_FFFF);
		push_offset(19, 0);
		push_offset(14, 13);
		pix_in.valid <= 1'b0;

		// ring width clamped to half the radius
		apply_setup(64, 64, 20, 2047, MODE_RING, 32'hFF00_0000);
		push_offset(12, 0);
		push_offset(5, 5);
		pix_in.valid <= 1'b0;

		// largest radius and box
		apply_setup(4095, 4095, 2047, 1, MODE_FILL, 32'h7F00_FF00);
		push_offset(2046, 2046);
		push_offset(2046, 0);
		push_offset(1447, 1447);
		pix_in.valid <= 1'b0;

		// box clamps radius to one, ring clamped to zero width
		apply_setup(3, 4095, 10, 5, MODE_RING, 32'hFFC0_FFEE);
		push_offset(0, 0);
		pix_in.valid <= 1'b0;

		// box clamps radius to zero
		apply_setup(1, 64, 10, 1, MODE_FILL, 32'hFFFF_FFFF);
		push_offset(0, 0);
		pix_in.valid <= 1'b0;

		// corners disabled by a radius of one and of zero
		apply_setup(64, 64, 1, 1, MODE_FILL, 32'hFFFF_FFFF);
		push_offset(0, 0);
		pix_in.valid <= 1'b0;
		apply_setup(0, 0, 0, 0, MODE_FILL, 32'h0000_0000);
		push_offset(0, 0);
		pix_in.valid <= 1'b0;

		// transparent foreground
		apply_setup(64, 64, 20, 1, MODE_FILL, 32'h00FF_FFFF);
		push_offset(0, 0);
		pix_in.valid <= 1'b0;

		// random register settings, each followed by a burst run of offsets
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			bw = pick_box();
			bh = pick_box();
			case ($urandom_range(0, 9))
				0: r = $urandom_range(0, 1);
				1: r = (1 << RAD_W) - 1;
				2: r = $urandom_range(0, (1 << RAD_W) - 1);
				default: r = $urandom_range(2, 64);
			endcase
			case ($urandom_range(0, 5))
				0: rw = 0;
				1: rw = 1;
				2: rw = (1 << RAD_W) - 1;
				3: rw = $urandom_range(0, (1 << RAD_W) - 1);
				default: rw = $urandom_range(0, r);
			endcase
			color = $urandom;
			case ($urandom_range(0, 7))
				0, 1: color[31:24] = 8'hFF;
				2: color[31:24] = 8'h00;
				default: ;
			endcase
			apply_setup(bw, bh, r, rw, 1'($urandom_range(0, 1)), color);
			run_offsets(PHASE_ITEMS, p == 1, p == 4);
		end

		wait_idle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0 && outstanding == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/rcca_pkg.sv
rtl/rcca_if.sv
rtl/rcca_cfg.sv
rtl/rcca_sqr.sv
rtl/rcca_cmp.sv
rtl/rcca_shade.sv
rtl/rounded_corner_coverage_alpha_core.sv
verif/rcca_alpha_checker.sv
verif/testbench.sv
